FILE: rtl/sgr_pkg.sv
// ---------------------------------------------------------------------------
// sgr_pkg
// shared widths, defaults and the sequencer state codes for the stream group
// reverser
// ---------------------------------------------------------------------------
package sgr_pkg;

  localparam int VALUE_W        = 32;
  localparam int GROUP_SIZE_W   = 5;
  localparam int MAX_GROUP_DEF  = 16;
  localparam logic [GROUP_SIZE_W-1:0] GROUP_SIZE_RST = GROUP_SIZE_W'(4);

  localparam int STATE_W = 2;
  localparam logic [STATE_W-1:0] S_IN = 2'd0;
  localparam logic [STATE_W-1:0] S_RD = 2'd1;
  localparam logic [STATE_W-1:0] S_LD = 2'd2;

endpackage

FILE: rtl/stream_group_reverser.sv
// ---------------------------------------------------------------------------
// stream_group_reverser
// collects values into a group buffer and drains each full group reversed,
// a short final group in arrival order
// ---------------------------------------------------------------------------
// an item that does not close a group is only written into the buffer; an
// item that closes a group of n starts a drain of n results: the sequencer
// issues a buffer read, the registered read data is loaded into the output
// register when free, then one result per cycle while out_ready is high
// input is held off during the drain; reset clears fill count, sequencer,
// output valid, group size to 4; buffer contents are not cleared
// ---------------------------------------------------------------------------
module stream_group_reverser #(
  parameter int MAX_GROUP = sgr_pkg::MAX_GROUP_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [sgr_pkg::VALUE_W-1:0] in_value,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sgr_pkg::VALUE_W-1:0] out_value_res,
  output logic                              out_last_res,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sgr_pkg::GROUP_SIZE_W-1:0]  cfg_group_size
);
  import sgr_pkg::*;

  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CW = $clog2(MAX_GROUP + 1);
  localparam int EW = (CW > GROUP_SIZE_W) ? CW : GROUP_SIZE_W;

  logic [STATE_W-1:0]      state_r, state_nxt;
  logic [CW-1:0]           fill_r, fill_nxt;
  logic [CW-1:0]           rem_r, rem_nxt;
  logic [AW-1:0]           addr_r, addr_nxt;
  logic                    rev_r, rev_nxt;
  logic                    fin_r, fin_nxt;
  logic [GROUP_SIZE_W-1:0] size_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]      out_value_r, out_value_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    in_xfer;
  logic                    out_free;
  logic [EW-1:0]           eff_size;
  logic [EW-1:0]           n_ext;
  logic [CW-1:0]           n;
  logic [AW-1:0]           step_addr;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic [VALUE_W-1:0]      rd_data;

  assign in_ready  = (state_r == S_IN);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    if (size_r == '0) begin
      eff_size = EW'(1);
    end else if (EW'(size_r) > EW'(MAX_GROUP)) begin
      eff_size = EW'(MAX_GROUP);
    end else begin
      eff_size = EW'(size_r);
    end
  end

  assign n         = fill_r + CW'(1);
  assign n_ext     = EW'(n);
  assign step_addr = rev_r ? (addr_r - AW'(1)) : (addr_r + AW'(1));

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    rem_nxt       = rem_r;
    addr_nxt      = addr_r;
    rev_nxt       = rev_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    rd_en         = 1'b0;
    rd_addr       = addr_r;
    unique case (state_r)
      S_IN: begin
        if (in_xfer) begin
          fin_nxt = in_last;
          if (n_ext >= eff_size) begin
            rev_nxt   = 1'b1;
            addr_nxt  = fill_r[AW-1:0];
            rem_nxt   = fill_r;
            fill_nxt  = '0;
            state_nxt = S_RD;
          end else if (in_last) begin
            rev_nxt   = 1'b0;
            addr_nxt  = '0;
            rem_nxt   = fill_r;
            fill_nxt  = '0;
            state_nxt = S_RD;
          end else begin
            fill_nxt = n;
          end
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_LD;
      end
      S_LD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = rd_data;
          out_last_nxt  = fin_r && (rem_r == '0);
          if (rem_r != '0) begin
            rd_en    = 1'b1;
            rd_addr  = step_addr;
            addr_nxt = step_addr;
            rem_nxt  = rem_r - CW'(1);
          end else begin
            state_nxt = S_IN;
          end
        end
      end
      default: begin
        state_nxt = S_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IN;
      fill_r      <= '0;
      size_r      <= GROUP_SIZE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        size_r <= cfg_group_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    addr_r      <= addr_nxt;
    rev_r       <= rev_nxt;
    fin_r       <= fin_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  sgr_buf #(
    .DEPTH (MAX_GROUP),
    .AW    (AW),
    .DW    (VALUE_W)
  ) u_buf (
    .clk     (clk),
    .wr_en   (in_xfer),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data (in_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_r;
  assign out_last_res  = out_last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    EW'(fill_r) < EW'(MAX_GROUP))
    else $error("fill count reached buffer depth");

  a_rd_to_ld: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |=> state_r == S_LD)
    else $error("read issue not followed by load");

  a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_last |=> fill_r == '0 && state_r == S_RD)
    else $error("final element did not start a drain");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LD && out_free |=> out_valid_r)
    else $error("drain load did not present a result");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LD && out_free && rem_r == '0 |=> state_r == S_IN)
    else $error("drain did not end after its final result");

endmodule

FILE: rtl/sgr_buf.sv
// ---------------------------------------------------------------------------
// sgr_buf
// group buffer: one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module sgr_buf #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
